[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file dday_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge, but not while reset is asserted.
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Checked on every clock edge, reset included.
`define ASSERT_ANY(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

[hdl/dday_pkg.sv]
// ----------------------------------------------------------------------------
// dday_pkg
// Widths, constants and month tables for the date difference pipeline.
// ----------------------------------------------------------------------------
package dday_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MON_W   = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned COUNT_W = 22;
  // Day number of 31 Dec 16383 is below 2^23.
  localparam int unsigned DNUM_W  = 23;
  // Quotient of a 14-bit value by 100.
  localparam int unsigned QUO_W   = 8;
  // Remainder by 100.
  localparam int unsigned REM_W   = 7;
  // Days before month plus leap day plus day of month, at most 366.
  localparam int unsigned MDAY_W  = 9;

  // floor(x / 100) == (x * DIV100_MUL) >> DIV100_SH for x < 2^14
  localparam int unsigned DIV100_SH  = 19;
  localparam int unsigned MUL_W      = 27;
  localparam logic [MUL_W-1:0] DIV100_MUL = MUL_W'(5243);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [MON_W-1:0] MON_JAN = MON_W'(1);
  localparam logic [MON_W-1:0] MON_FEB = MON_W'(2);
  localparam logic [MON_W-1:0] MON_DEC = MON_W'(12);

  localparam logic [DAY_W-1:0] FEB_LEN_LEAP   = DAY_W'(29);
  localparam logic [DAY_W-1:0] FEB_LEN_COMMON = DAY_W'(28);

  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
  } date_t;

  // Control that travels down the pipeline beside the data.
  typedef struct packed {
    logic vld;
    logic inc;
  } pipe_ctl_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                     len = DAY_W'(30);
      4'd2:                                        len = FEB_LEN_COMMON;
      default:                                     len = '0;
    endcase
    return len;
  endfunction

  function automatic logic [MDAY_W-1:0] days_before_month(input logic [MON_W-1:0] m);
    logic [MDAY_W-1:0] n;
    unique case (m)
      4'd2:    n = MDAY_W'(31);
      4'd3:    n = MDAY_W'(59);
      4'd4:    n = MDAY_W'(90);
      4'd5:    n = MDAY_W'(120);
      4'd6:    n = MDAY_W'(151);
      4'd7:    n = MDAY_W'(181);
      4'd8:    n = MDAY_W'(212);
      4'd9:    n = MDAY_W'(243);
      4'd10:   n = MDAY_W'(273);
      4'd11:   n = MDAY_W'(304);
      4'd12:   n = MDAY_W'(334);
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

[hdl/dday_in_if.sv]
// ----------------------------------------------------------------------------
// dday_in_if
// Input channel: a start date, an end date and the include-end flag.
// ----------------------------------------------------------------------------
interface dday_in_if
  import dday_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   start_day;
  logic [MON_W-1:0]   start_month;
  logic [YEAR_W-1:0]  start_year;
  logic [DAY_W-1:0]   end_day;
  logic [MON_W-1:0]   end_month;
  logic [YEAR_W-1:0]  end_year;
  logic               include_end_day;

  modport source (
    output valid, start_day, start_month, start_year,
           end_day, end_month, end_year, include_end_day,
    input  ready
  );

  modport sink (
    input  valid, start_day, start_month, start_year,
           end_day, end_month, end_year, include_end_day,
    output ready
  );
endinterface

[hdl/dday_out_if.sv]
// ----------------------------------------------------------------------------
// dday_out_if
// Output channel: day count and date error flag.
// ----------------------------------------------------------------------------
interface dday_out_if
  import dday_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] day_count;
  logic               date_error;

  modport source (
    output valid, day_count, date_error,
    input  ready
  );

  modport sink (
    input  valid, day_count, date_error,
    output ready
  );
endinterface

[hdl/date_difference_in_days.sv]
// ----------------------------------------------------------------------------
// date_difference_in_days
// Path: each input beat passes registers A, B and C, then the output register D.
// Throughput: one date pair per cycle while the output is not stalled; the four stages advance together.
// Stall: the whole pipeline freezes while a held output beat is not taken.
// Reset: asynchronous, clears the valid and include-end control bits only; no other state.
// ----------------------------------------------------------------------------
module date_difference_in_days
  import dday_pkg::*;
#(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  dday_in_if.sink    in_i,
  dday_out_if.source out_o
);

  // Pipeline map:
  //   A  year - 1, quotients by 100 (reciprocal multiply), coarse range checks
  //   B  leap rule, month length check, days in whole years, days into year
  //   C  day number = year days + month days + day
  //   D  end - start, zero when not later, clamp, add end day, error flag
  // A and B and C live in one date unit per date; D is the output register.

  // One enable for all stages: move when the output slot is empty or taken.
  logic en;
  assign en       = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // Valid and the include flag ride alongside stages A to C.
  pipe_ctl_t ctl_in;
  pipe_ctl_t ctl_q [3];

  assign ctl_in.vld = in_i.valid;
  assign ctl_in.inc = in_i.include_end_day;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '0;
      ctl_q[1] <= '0;
      ctl_q[2] <= '0;
    end else if (en) begin
      ctl_q[0] <= ctl_in;
      ctl_q[1] <= ctl_q[0];
      ctl_q[2] <= ctl_q[1];
    end
  end

  date_t             start_date, end_date;
  logic [DNUM_W-1:0] start_num,  end_num;
  logic              start_ok,   end_ok;

  assign start_date.day   = in_i.start_day;
  assign start_date.month = in_i.start_month;
  assign start_date.year  = in_i.start_year;
  assign end_date.day     = in_i.end_day;
  assign end_date.month   = in_i.end_month;
  assign end_date.year    = in_i.end_year;

  // Two identical day-number units, one per date.
  dday_date_unit #(
    .MAX_YEAR (MAX_YEAR)
  ) u_start (
    .clk_i     (clk_i),
    .en_i      (en),
    .date_i    (start_date),
    .day_num_o (start_num),
    .ok_o      (start_ok)
  );

  dday_date_unit #(
    .MAX_YEAR (MAX_YEAR)
  ) u_end (
    .clk_i     (clk_i),
    .en_i      (en),
    .date_i    (end_date),
    .day_num_o (end_num),
    .ok_o      (end_ok)
  );

  // Stage D doubles as the output register of the out channel.
  dday_diff u_diff (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .ctl_i        (ctl_q[2]),
    .start_num_i  (start_num),
    .end_num_i    (end_num),
    .start_ok_i   (start_ok),
    .end_ok_i     (end_ok),
    .valid_o      (out_o.valid),
    .day_count_o  (out_o.day_count),
    .date_error_o (out_o.date_error)
  );

endmodule

[hdl/dday_date_unit.sv]
// ----------------------------------------------------------------------------
// dday_date_unit
// Three-stage day number and validity check for one date.
// ----------------------------------------------------------------------------
module dday_date_unit
  import dday_pkg::*;
#(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  date_t             date_i,
  output logic [DNUM_W-1:0] day_num_o,
  output logic              ok_o
);

  // Stage A: split year, reciprocal divides by 100
  logic [DAY_W-1:0]  day_q,   day_d;
  logic [MON_W-1:0]  mon_q,   mon_d;
  logic [YEAR_W-1:0] year_q,  year_d;
  logic [YEAR_W-1:0] prev_q,  prev_d;
  logic [QUO_W-1:0]  pquo_q,  pquo_d;
  logic [QUO_W-1:0]  yquo_q,  yquo_d;
  logic              oka_q,   oka_d;
  logic [MUL_W-1:0]  pprod, yprod;

  always_comb begin
    day_d  = date_i.day;
    mon_d  = date_i.month;
    year_d = date_i.year;
    prev_d = date_i.year - YEAR_W'(1);
    pprod  = MUL_W'(prev_d) * DIV100_MUL;
    yprod  = MUL_W'(date_i.year) * DIV100_MUL;
    pquo_d = pprod[DIV100_SH +: QUO_W];
    yquo_d = yprod[DIV100_SH +: QUO_W];
    oka_d  = (date_i.month >= MON_JAN) && (date_i.month <= MON_DEC) &&
             (date_i.year != '0) && (32'(date_i.year) <= 32'(MAX_YEAR)) &&
             (date_i.day != '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      day_q  <= day_d;
      mon_q  <= mon_d;
      year_q <= year_d;
      prev_q <= prev_d;
      pquo_q <= pquo_d;
      yquo_q <= yquo_d;
      oka_q  <= oka_d;
    end
  end

  // Stage B: leap rule, month length, days in whole years and in the year
  logic [DNUM_W-1:0] ydays_q, ydays_d;
  logic [MDAY_W-1:0] mdays_q, mdays_d;
  logic              okb_q,   okb_d;
  logic [YEAR_W:0]   hund;
  logic [REM_W-1:0]  yrem;
  logic              leap;
  logic [DAY_W-1:0]  len;
  logic [DNUM_W-1:0] pw, qw;

  always_comb begin
    hund = (YEAR_W+1)'(yquo_q) * (YEAR_W+1)'(100);
    yrem = REM_W'({1'b0, year_q} - hund);
    leap = ((year_q[1:0] == 2'b00) && (yrem != '0)) ||
           ((yrem == '0) && (yquo_q[1:0] == 2'b00));
    if (mon_q == MON_FEB) begin
      len = leap ? FEB_LEN_LEAP : FEB_LEN_COMMON;
    end else begin
      len = month_len(mon_q);
    end
    okb_d   = oka_q && (day_q <= len);
    pw      = DNUM_W'(prev_q);
    qw      = DNUM_W'(pquo_q);
    ydays_d = pw * DNUM_W'(365) + (pw >> 2) - qw + (qw >> 2);
    mdays_d = days_before_month(mon_q) + MDAY_W'(day_q) +
              MDAY_W'(leap && (mon_q > MON_FEB));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ydays_q <= ydays_d;
      mdays_q <= mdays_d;
      okb_q   <= okb_d;
    end
  end

  // Stage C: final day number
  logic [DNUM_W-1:0] dnum_q;
  logic              okc_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dnum_q <= ydays_q + DNUM_W'(mdays_q);
      okc_q  <= okb_q;
    end
  end

  assign day_num_o = dnum_q;
  assign ok_o      = okc_q;

endmodule

[hdl/dday_diff.sv]
// ----------------------------------------------------------------------------
// dday_diff
// Subtract, clamp and add the end day; holds the output beat.
// ----------------------------------------------------------------------------
module dday_diff
  import dday_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  pipe_ctl_t          ctl_i,
  input  logic [DNUM_W-1:0]  start_num_i,
  input  logic [DNUM_W-1:0]  end_num_i,
  input  logic               start_ok_i,
  input  logic               end_ok_i,
  output logic               valid_o,
  output logic [COUNT_W-1:0] day_count_o,
  output logic               date_error_o
);

  logic               valid_q;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               err_q,   err_d;
  logic [DNUM_W-1:0]  span;

  always_comb begin
    span  = (start_num_i < end_num_i) ? (end_num_i - start_num_i) : '0;
    err_d = !(start_ok_i && end_ok_i);
    if (err_d) begin
      count_d = '0;
    end else if (span >= DNUM_W'(COUNT_MAX)) begin
      count_d = COUNT_MAX;
    end else begin
      count_d = span[COUNT_W-1:0] + COUNT_W'(ctl_i.inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

  assign valid_o      = valid_q;
  assign day_count_o  = count_q;
  assign date_error_o = err_q;

endmodule

[hdl/dday_checker.sv]
// ----------------------------------------------------------------------------
// dday_checker
// Port-level checks for date_difference_in_days, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dday_checker
  import dday_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [COUNT_W-1:0] day_count_i,
  input logic               date_error_i
);

  // A held beat keeps its payload.
  `ASSERT_RST(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(day_count_i) && $stable(date_error_i))

  // An error beat never carries a count.
  `ASSERT_RST(a_err_zero, clk_i, rst_ni, out_valid_i && date_error_i |-> day_count_i == '0)

  // Input back-pressure only comes from a stalled output.
  `ASSERT_RST(a_ready_stall, clk_i, rst_ni, (in_ready_i == 1'b0) == (out_valid_i && !out_ready_i))

  // Nothing comes out right after reset.
  `ASSERT_ANY(a_reset_empty, clk_i, !rst_ni |=> !out_valid_i)

endmodule

bind date_difference_in_days dday_checker u_dday_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .day_count_i  (out_o.day_count),
  .date_error_i (out_o.date_error)
);
